### rtl/core/pasm_pkg.sv
// Shared types, constants and helpers for the polynomial add/sub/multiply block.
// No dependencies; used by every module under rtl/core except pasm_ram.
`timescale 1ns / 1ps

package pasm_pkg;

  localparam int MAX_DEGREE   = 15;
  localparam int COEFF_WIDTH  = 16;
  localparam int STORE_DEPTH  = MAX_DEGREE + 1;
  localparam int RESULT_DEPTH = 2 * MAX_DEGREE + 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int INDEX_W      = 4;   // coeff_index port
  localparam int DEG_W        = 4;   // degree registers
  localparam int POW_W        = 5;   // result_power port
  localparam int RES_W        = 36;  // result_coeff port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;

  typedef enum logic [1:0] {
    OPC_LOAD_A  = 2'd0,
    OPC_LOAD_B  = 2'd1,
    OPC_COMPUTE = 2'd2,
    OPC_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_INV = 2'd3
  } oper_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE_A  = 2'd0,
    REG_DEGREE_B  = 2'd1,
    REG_OPERATION = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  // One term issued by the controller into the datapath pipeline.
  typedef struct packed {
    logic              valid;
    oper_t             op;
    logic              first;      // first term of this power: restart accumulator
    logic              last_term;  // last term of this power: emit result
    logic              last_item;  // constant term
    logic              err;
    logic              en_a;
    logic              en_b;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [POW_W-1:0]  power;
  } cmd_t;

  // Coefficient store write strobes.
  typedef struct packed {
    logic we_a;
    logic we_b;
  } load_t;

  function automatic logic [POW_W-1:0] clamp_degree(input logic [DEG_W-1:0] d);
    logic [POW_W-1:0] r;
    r = POW_W'(d);
    if (32'(d) > MAX_DEGREE) r = POW_W'(MAX_DEGREE);
    return r;
  endfunction

endpackage

### rtl/core/polynomial_add_sub_multiply.sv
// Dense polynomial add/subtract/multiply, top level. Depends on pasm_pkg and rtl/core.
// A compute's terms pass the sequencer, RAM stage, arithmetic stage and result register.
// Add/sub: max(da,db)+1 terms, one result each. Multiply: (da+1)*(db+1) terms, one
// multiply-accumulate each, via the single multiplier and one read port per store.
// busy clears as the last term leaves the arithmetic stage. Results strobe for one cycle;
// the receiver cannot stall. Synchronous active-high reset clears config and control.
`timescale 1ns / 1ps

module polynomial_add_sub_multiply (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              opcode,
  input  logic [pasm_pkg::INDEX_W-1:0]            coeff_index,
  input  logic signed [pasm_pkg::COEFF_WIDTH-1:0] coeff_in,
  input  logic                                    cfg_we,
  input  logic [pasm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pasm_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                    result_valid,
  output logic [pasm_pkg::POW_W-1:0]              result_power,
  output logic signed [pasm_pkg::RES_W-1:0]       result_coeff,
  output logic                                    last,
  output logic                                    status
);

  pasm_pkg::load_t load;
  pasm_pkg::cmd_t  cmd;

  pasm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .coeff_index (coeff_index),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .load        (load),
    .cmd         (cmd)
  );

  pasm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .coeff_index  (coeff_index),
    .coeff_in     (coeff_in),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_power (result_power),
    .result_coeff (result_coeff),
    .last         (last),
    .status       (status)
  );

endmodule

### rtl/core/pasm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pasm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/pasm_ctrl.sv
// Controller: configuration registers, input transfer and the term sequencer.
// Depends on pasm_pkg.
`timescale 1ns / 1ps

module pasm_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode,
  input  logic [pasm_pkg::INDEX_W-1:0]       coeff_index,
  input  logic                               cfg_we,
  input  logic [pasm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pasm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pasm_pkg::load_t                    load,
  output pasm_pkg::cmd_t                     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_ERR,
    S_DRAIN
  } state_t;

  state_t                       state;
  logic [pasm_pkg::DEG_W-1:0]   degree_a;
  logic [pasm_pkg::DEG_W-1:0]   degree_b;
  pasm_pkg::oper_t              operation;
  logic [pasm_pkg::POW_W-1:0]   k;
  logic [pasm_pkg::ADDR_W-1:0]  i;
  logic                         drain;

  logic [pasm_pkg::POW_W-1:0]   da, db, rdeg, k_dec;
  logic [pasm_pkg::ADDR_W-1:0]  lo_k, hi_k, lo_next;
  logic                         accept;
  pasm_pkg::opcode_t            opc;

  // Lowest i with k-i <= db, for the convolution walk.
  function automatic logic [pasm_pkg::ADDR_W-1:0] low_of(
    input logic [pasm_pkg::POW_W-1:0] x,
    input logic [pasm_pkg::POW_W-1:0] dbv
  );
    logic [pasm_pkg::ADDR_W-1:0] r;
    r = '0;
    if (x > dbv) r = pasm_pkg::ADDR_W'(x - dbv);
    return r;
  endfunction

  assign opc    = pasm_pkg::opcode_t'(opcode);
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign da     = pasm_pkg::clamp_degree(degree_a);
  assign db     = pasm_pkg::clamp_degree(degree_b);
  assign k_dec  = k - pasm_pkg::POW_W'(1);
  assign lo_k   = low_of(k, db);
  assign hi_k   = (k > da) ? pasm_pkg::ADDR_W'(da) : pasm_pkg::ADDR_W'(k);

  always_comb begin
    if (operation == pasm_pkg::OP_MUL) begin
      rdeg    = da + db;
      lo_next = low_of(k_dec, db);
    end else begin
      rdeg    = (da > db) ? da : db;
      lo_next = pasm_pkg::ADDR_W'(k_dec);
    end
  end

  always_comb begin
    load.we_a = accept && (opc == pasm_pkg::OPC_LOAD_A) &&
                (32'(coeff_index) <= pasm_pkg::MAX_DEGREE);
    load.we_b = accept && (opc == pasm_pkg::OPC_LOAD_B) &&
                (32'(coeff_index) <= pasm_pkg::MAX_DEGREE);
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = operation;
    cmd.power     = k;
    unique case (state)
      S_RUN: begin
        cmd.valid = 1'b1;
        if (operation == pasm_pkg::OP_MUL) begin
          cmd.addr_a    = i;
          cmd.addr_b    = pasm_pkg::ADDR_W'(k - pasm_pkg::POW_W'(i));
          cmd.first     = (i == lo_k);
          cmd.last_term = (i == hi_k);
          cmd.en_a      = 1'b1;
          cmd.en_b      = 1'b1;
        end else begin
          cmd.addr_a    = pasm_pkg::ADDR_W'(k);
          cmd.addr_b    = pasm_pkg::ADDR_W'(k);
          cmd.first     = 1'b1;
          cmd.last_term = 1'b1;
          cmd.en_a      = (k <= da);
          cmd.en_b      = (k <= db);
        end
        cmd.last_item = cmd.last_term && (k == '0);
      end
      S_ERR: begin
        cmd.valid     = 1'b1;
        cmd.err       = 1'b1;
        cmd.first     = 1'b1;
        cmd.last_term = 1'b1;
        cmd.last_item = 1'b1;
        cmd.power     = '0;
      end
      S_IDLE, S_DRAIN: begin
        cmd.valid = 1'b0;
      end
      default: cmd.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      degree_a  <= '0;
      degree_b  <= '0;
      operation <= pasm_pkg::OP_ADD;
      k         <= '0;
      i         <= '0;
      drain     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (pasm_pkg::cfg_reg_t'(cfg_index))
          pasm_pkg::REG_DEGREE_A:  degree_a  <= cfg_data;
          pasm_pkg::REG_DEGREE_B:  degree_b  <= cfg_data;
          pasm_pkg::REG_OPERATION: operation <= pasm_pkg::oper_t'(cfg_data[1:0]);
          pasm_pkg::REG_UNUSED:    ;
          default:                 ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && opc == pasm_pkg::OPC_COMPUTE) begin
            if (operation == pasm_pkg::OP_INV) begin
              state <= S_ERR;
            end else begin
              state <= S_RUN;
              k     <= rdeg;
              i     <= (operation == pasm_pkg::OP_MUL) ? low_of(rdeg, db)
                                                       : pasm_pkg::ADDR_W'(rdeg);
            end
          end
        end
        S_RUN: begin
          if (cmd.last_term) begin
            if (k == '0) begin
              state <= S_DRAIN;
              drain <= 1'b0;
            end else begin
              k <= k_dec;
              i <= lo_next;
            end
          end else begin
            i <= i + pasm_pkg::ADDR_W'(1);
          end
        end
        S_ERR: begin
          state <= S_DRAIN;
          drain <= 1'b0;
        end
        S_DRAIN: begin
          // the last term leaves the RAM stage, then the arithmetic stage
          drain <= 1'b1;
          if (drain) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> busy) else $error("term issued while not busy");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.last_item |=> !cmd.valid)
    else $error("term issued after constant term");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(load.we_a || load.we_b)) else $error("store write during compute");

  a_first_power: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && !cmd.last_term |=> cmd.valid && !cmd.first && cmd.power == $past(cmd.power))
    else $error("power changed inside a convolution sum");

endmodule

### rtl/core/pasm_datapath.sv
// Datapath: coefficient stores, multiply/add stage, accumulator, result register.
// Depends on pasm_pkg and pasm_ram.
`timescale 1ns / 1ps

module pasm_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pasm_pkg::load_t                        load,
  input  logic [pasm_pkg::INDEX_W-1:0]           coeff_index,
  input  logic signed [pasm_pkg::COEFF_WIDTH-1:0] coeff_in,
  input  pasm_pkg::cmd_t                         cmd,
  output logic                                   result_valid,
  output logic [pasm_pkg::POW_W-1:0]             result_power,
  output logic signed [pasm_pkg::RES_W-1:0]      result_coeff,
  output logic                                   last,
  output logic                                   status
);

  logic [pasm_pkg::COEFF_WIDTH-1:0]   rd_a, rd_b;
  logic [pasm_pkg::ADDR_W-1:0]        waddr;
  pasm_pkg::cmd_t                     s1;
  pasm_pkg::cmd_t                     s2;
  logic signed [pasm_pkg::RES_W-1:0]  s2_val;
  logic signed [pasm_pkg::RES_W-1:0]  acc;
  logic signed [pasm_pkg::RES_W-1:0]  a_x, b_x, val_next, sum;
  logic signed [pasm_pkg::COEFF_WIDTH-1:0] a_s, b_s;
  logic signed [2*pasm_pkg::COEFF_WIDTH-1:0] prod;

  assign waddr = pasm_pkg::ADDR_W'(coeff_index);

  pasm_ram #(.WIDTH(pasm_pkg::COEFF_WIDTH), .DEPTH(pasm_pkg::STORE_DEPTH)) u_store_a (
    .clk   (clk),
    .we    (load.we_a),
    .waddr (waddr),
    .wdata (coeff_in),
    .raddr (cmd.addr_a),
    .rdata (rd_a)
  );

  pasm_ram #(.WIDTH(pasm_pkg::COEFF_WIDTH), .DEPTH(pasm_pkg::STORE_DEPTH)) u_store_b (
    .clk   (clk),
    .we    (load.we_b),
    .waddr (waddr),
    .wdata (coeff_in),
    .raddr (cmd.addr_b),
    .rdata (rd_b)
  );

  // Missing coefficients of the shorter operand read as zero.
  assign a_s  = s1.en_a ? $signed(rd_a) : '0;
  assign b_s  = s1.en_b ? $signed(rd_b) : '0;
  assign a_x  = pasm_pkg::RES_W'(a_s);
  assign b_x  = pasm_pkg::RES_W'(b_s);
  assign prod = a_s * b_s;

  always_comb begin
    unique case (s1.op)
      pasm_pkg::OP_ADD: val_next = a_x + b_x;
      pasm_pkg::OP_SUB: val_next = a_x - b_x;
      pasm_pkg::OP_MUL: val_next = pasm_pkg::RES_W'(prod);
      pasm_pkg::OP_INV: val_next = '0;
      default:          val_next = '0;
    endcase
    if (s1.err) val_next = '0;
  end

  assign sum = (s2.first ? '0 : acc) + s2_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid     <= 1'b0;
      s2.valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1.valid     <= cmd.valid;
      s2.valid     <= s1.valid;
      result_valid <= s2.valid && s2.last_term;
    end
    // payload, no reset
    s1[$bits(pasm_pkg::cmd_t)-2:0] <= cmd[$bits(pasm_pkg::cmd_t)-2:0];
    s2[$bits(pasm_pkg::cmd_t)-2:0] <= s1[$bits(pasm_pkg::cmd_t)-2:0];
    s2_val <= val_next;
    if (s2.valid) begin
      acc <= sum;
    end
    if (s2.valid && s2.last_term) begin
      result_power <= s2.power;
      result_coeff <= sum;
      last         <= s2.last_item;
      status       <= s2.err;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> last && result_power == '0 && result_coeff == '0)
    else $error("error result malformed");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid) else $error("result after constant term");

  a_power_down: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> !result_valid ||
      result_power == $past(result_power) - pasm_pkg::POW_W'(1))
    else $error("result powers not descending by one");

endmodule

### test/tb_polynomial_add_sub_multiply.sv
// Self-checking testbench for polynomial_add_sub_multiply: loads, add/sub/multiply computes
// and the invalid-operation result, checked term by term against an in-bench predictor.
// Depends on pasm_pkg and the polynomial_add_sub_multiply RTL.
`timescale 1ns / 1ps

module tb_polynomial_add_sub_multiply;

  localparam int MAX_REPORTS = 20;

  typedef struct {
    pasm_pkg::opcode_t                       opc;
    logic [pasm_pkg::INDEX_W-1:0]            idx;
    logic signed [pasm_pkg::COEFF_WIDTH-1:0] val;
  } poly_cmd_t;

  typedef struct {
    logic [pasm_pkg::POW_W-1:0]        power;
    logic signed [pasm_pkg::RES_W-1:0] coeff;
    logic                              last;
    logic                              status;
  } term_t;

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    start = 1'b0;
  logic                                    busy;
  logic [1:0]                              opcode = '0;
  logic [pasm_pkg::INDEX_W-1:0]            coeff_index = '0;
  logic signed [pasm_pkg::COEFF_WIDTH-1:0] coeff_in = '0;
  logic                                    cfg_we = 1'b0;
  logic [pasm_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
  logic [pasm_pkg::CFG_DATA_W-1:0]         cfg_data = '0;
  logic                                    result_valid;
  logic [pasm_pkg::POW_W-1:0]              result_power;
  logic signed [pasm_pkg::RES_W-1:0]       result_coeff;
  logic                                    last;
  logic                                    status;

  poly_cmd_t cmd_queue[$];
  term_t     term_queue[$];
  int        gap_pct = 22;
  logic      took = 1'b0;

  // predictor copy of the coefficient stores and the configuration
  logic signed [pasm_pkg::COEFF_WIDTH-1:0] mirror_a [pasm_pkg::STORE_DEPTH];
  logic signed [pasm_pkg::COEFF_WIDTH-1:0] mirror_b [pasm_pkg::STORE_DEPTH];
  logic [pasm_pkg::DEG_W-1:0] cur_deg_a = '0;
  logic [pasm_pkg::DEG_W-1:0] cur_deg_b = '0;
  pasm_pkg::oper_t            cur_oper = pasm_pkg::OP_ADD;

  int errors = 0;
  int n_xfers = 0;
  int n_terms = 0;
  int n_ops [4] = '{default: 0};

  polynomial_add_sub_multiply u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .coeff_index  (coeff_index),
    .coeff_in     (coeff_in),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_power (result_power),
    .result_coeff (result_coeff),
    .last         (last),
    .status       (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Updates the store copies for a load, or queues the terms a compute produces.
  task automatic compute_terms(input poly_cmd_t c);
    longint acc [pasm_pkg::RESULT_DEPTH];
    longint ca, cb;
    int     top;
    term_t  t;
    case (c.opc)
      pasm_pkg::OPC_LOAD_A: mirror_a[c.idx] = c.val;
      pasm_pkg::OPC_LOAD_B: mirror_b[c.idx] = c.val;
      pasm_pkg::OPC_COMPUTE: begin
        n_ops[cur_oper]++;
        if (cur_oper == pasm_pkg::OP_INV) begin
          t.power  = '0;
          t.coeff  = '0;
          t.last   = 1'b1;
          t.status = 1'b1;
          term_queue.push_back(t);
        end else begin
          foreach (acc[k]) acc[k] = 0;
          if (cur_oper == pasm_pkg::OP_MUL) begin
            top = cur_deg_a + cur_deg_b;
            for (int i = 0; i <= cur_deg_a; i++)
              for (int j = 0; j <= cur_deg_b; j++)
                acc[i + j] += longint'(mirror_a[i]) * longint'(mirror_b[j]);
          end else begin
            top = (cur_deg_a > cur_deg_b) ? cur_deg_a : cur_deg_b;
            for (int i = 0; i <= top; i++) begin
              // the shorter polynomial contributes zero above its degree
              ca = (i <= cur_deg_a) ? longint'(mirror_a[i]) : 0;
              cb = (i <= cur_deg_b) ? longint'(mirror_b[i]) : 0;
              acc[i] = (cur_oper == pasm_pkg::OP_ADD) ? ca + cb : ca - cb;
            end
          end
          for (int p = top; p >= 0; p--) begin
            t.power  = pasm_pkg::POW_W'(p);
            t.coeff  = acc[p][pasm_pkg::RES_W-1:0];
            t.last   = (p == 0);
            t.status = 1'b0;
            term_queue.push_back(t);
          end
        end
      end
      default: ;
    endcase
  endtask

  // monitor: config mirror, accepted transfers, result checking
  always @(posedge clk) begin
    term_t want;
    if (rst) begin
      took      <= 1'b0;
      cur_deg_a <= '0;
      cur_deg_b <= '0;
      cur_oper  <= pasm_pkg::OP_ADD;
    end else begin
      took <= start && !busy;
      if (cfg_we) begin
        case (pasm_pkg::cfg_reg_t'(cfg_index))
          pasm_pkg::REG_DEGREE_A:  cur_deg_a <= cfg_data;
          pasm_pkg::REG_DEGREE_B:  cur_deg_b <= cfg_data;
          pasm_pkg::REG_OPERATION: cur_oper  <= pasm_pkg::oper_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        n_xfers++;
        compute_terms('{pasm_pkg::opcode_t'(opcode), coeff_index, coeff_in});
      end
      if (result_valid) begin
        if (term_queue.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"%0t: unexpected result: expected none, ",
                      "actual power %0d coeff %0d last %0b status %0b"},
                     $time, result_power, result_coeff, last, status);
        end else begin
          want = term_queue.pop_front();
          n_terms++;
          if (result_power !== want.power || result_coeff !== want.coeff ||
              last !== want.last || status !== want.status) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: mismatch: expected power %0d coeff %0d last %0b status %0b, ",
                        "actual power %0d coeff %0d last %0b status %0b"},
                       $time, want.power, want.coeff, want.last, want.status,
                       result_power, result_coeff, last, status);
          end
        end
      end
    end
  end

  // driver: holds start until the transfer, then optionally idles
  always @(negedge clk) begin
    poly_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        nxt = cmd_queue.pop_front();
        start       <= 1'b1;
        opcode      <= nxt.opc;
        coeff_index <= nxt.idx;
        coeff_in    <= nxt.val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_cmd(input pasm_pkg::opcode_t o,
                          input logic [pasm_pkg::INDEX_W-1:0] i,
                          input logic signed [pasm_pkg::COEFF_WIDTH-1:0] v);
    poly_cmd_t c;
    c.opc = o;
    c.idx = i;
    c.val = v;
    cmd_queue.push_back(c);
  endtask

  function automatic logic signed [pasm_pkg::COEFF_WIDTH-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [pasm_pkg::DEG_W-1:0] pick_degree();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 4'd15;
      default: return 4'($urandom);
    endcase
  endfunction

  // everything sent, every term back, and the block no longer busy
  task automatic wait_idle();
    do @(posedge clk); while (cmd_queue.size() != 0 || start || term_queue.size() != 0);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input pasm_pkg::cfg_reg_t r,
                           input logic [pasm_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
  endtask

  task automatic configure(input logic [pasm_pkg::DEG_W-1:0] da,
                           input logic [pasm_pkg::DEG_W-1:0] db,
                           input pasm_pkg::oper_t op);
    wait_idle();
    write_reg(pasm_pkg::REG_DEGREE_A, da);
    write_reg(pasm_pkg::REG_DEGREE_B, db);
    // upper data bits are don't-care for the operation register
    write_reg(pasm_pkg::REG_OPERATION, {2'($urandom), op});
    write_reg(pasm_pkg::REG_UNUSED, 4'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(inout int budget);
    pasm_pkg::oper_t op;
    op = ($urandom_range(0, 9) == 0) ? pasm_pkg::OP_INV
                                     : pasm_pkg::oper_t'($urandom_range(0, 2));
    configure(pick_degree(), pick_degree(), op);
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 5)) begin
        push_cmd($urandom_range(0, 1) ? pasm_pkg::OPC_LOAD_B : pasm_pkg::OPC_LOAD_A,
                 4'($urandom), pick_coeff());
        budget--;
      end
      if ($urandom_range(0, 7) == 0)
        push_cmd(pasm_pkg::OPC_NONE, 4'($urandom), 16'($urandom));
      push_cmd(pasm_pkg::OPC_COMPUTE, 4'($urandom), 16'($urandom));
      budget--;
    end
  endtask

  initial begin
    int budget;
    int gaps [3];
    gaps = '{22, 54, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill both stores with the most negative value so every entry is defined
    for (int i = 0; i < pasm_pkg::STORE_DEPTH; i++) begin
      push_cmd(pasm_pkg::OPC_LOAD_A, 4'(i), 16'sh8000);
      push_cmd(pasm_pkg::OPC_LOAD_B, 4'(i), 16'sh8000);
    end
    push_cmd(pasm_pkg::OPC_NONE, 4'hf, 16'sh7fff);
    configure(4'd15, 4'd15, pasm_pkg::OP_MUL);   // largest product sum at the middle power
    push_cmd(pasm_pkg::OPC_COMPUTE, '0, '0);
    configure(4'd15, 4'd15, pasm_pkg::OP_ADD);
    push_cmd(pasm_pkg::OPC_COMPUTE, '0, '0);
    configure(4'd15, 4'd0, pasm_pkg::OP_SUB);
    push_cmd(pasm_pkg::OPC_LOAD_A, 4'd15, 16'sh7fff);
    push_cmd(pasm_pkg::OPC_LOAD_A, 4'd0, 16'sh7fff);
    push_cmd(pasm_pkg::OPC_LOAD_B, 4'd8, '0);
    push_cmd(pasm_pkg::OPC_COMPUTE, 4'hf, 16'shffff);
    configure(4'd0, 4'd15, pasm_pkg::OP_MUL);
    push_cmd(pasm_pkg::OPC_COMPUTE, '0, '0);
    configure(4'd3, 4'd9, pasm_pkg::OP_ADD);
    push_cmd(pasm_pkg::OPC_COMPUTE, '0, '0);
    configure(4'd0, 4'd0, pasm_pkg::OP_INV);
    push_cmd(pasm_pkg::OPC_COMPUTE, '0, '0);
    configure(4'd0, 4'd0, pasm_pkg::OP_SUB);
    push_cmd(pasm_pkg::OPC_COMPUTE, '0, '0);

    foreach (gaps[g]) begin
      wait_idle();
      gap_pct = gaps[g];
      budget = 38;
      while (budget > 0) random_phase(budget);
    end
    wait_idle();

    $display("Run covered %0d transfers and %0d result terms checked;", n_xfers, n_terms);
    $display("computes: add %0d, subtract %0d, multiply %0d, invalid %0d.",
             n_ops[pasm_pkg::OP_ADD], n_ops[pasm_pkg::OP_SUB],
             n_ops[pasm_pkg::OP_MUL], n_ops[pasm_pkg::OP_INV]);
    if (errors == 0 && term_queue.size() == 0)
      $display("[polynomial_add_sub_multiply] OK");
    else
      $display("[polynomial_add_sub_multiply] ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d result terms outstanding", term_queue.size());
    $display("[polynomial_add_sub_multiply] ERROR");
    $finish;
  end

endmodule
